[src/swm_pkg.sv]
// Shared types, sizes and helpers for the sliding window maximum unit.
// No dependencies; every module of the block imports this package.
package swm_pkg;

    // Longest window the cell row covers, and the sample width
    localparam int WINDOW_MAX  = 16;
    localparam int SAMPLE_BITS = 16;

    // Width of the window size register as written through the config port
    localparam int CFG_BITS = 5;

    // Width that holds any count from 0 to WINDOW_MAX
    localparam int WIN_BITS = $clog2(WINDOW_MAX + 1);

    // Window size after reset
    localparam logic [CFG_BITS-1:0] WSIZE_RESET = CFG_BITS'(3);

    // Max tree shape: groups of TREE_FAN cells reduced in the first stage
    localparam int TREE_FAN    = 4;
    localparam int TREE_GROUPS = (WINDOW_MAX + TREE_FAN - 1) / TREE_FAN;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // Most negative sample, used for empty cells in the max tree
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One cell of the row: an entry of the monotonic store
    typedef struct packed {
        logic    valid;
        sample_t value;
    } cell_t;

    function automatic sample_t max2(sample_t a, sample_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

[src/swm_cell.sv]
// One cell of the store row: holds one entry and takes its neighbor's entry on each sample.
// Depends on swm_pkg.
module swm_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  logic            load_new,
    input  logic            start_new,
    input  logic            in_range,
    input  swm_pkg::sample_t sample,
    input  swm_pkg::cell_t   prev,
    output swm_pkg::cell_t   cur
);
    import swm_pkg::*;

    cell_t cur_reg;
    cell_t cur_next;
    logic  dominated;

    // Take the new sample at the head, otherwise the neighbor's entry aged by one;
    // drop it on a restart, once it leaves the window or when the new sample is not smaller
    always_comb begin
        dominated = (prev.value <= sample);
        cur_next  = cur_reg;
        if (shift_en) begin
            if (load_new) begin
                cur_next.valid = 1'b1;
                cur_next.value = sample;
            end else begin
                cur_next.valid = prev.valid & ~start_new & in_range & ~dominated;
                cur_next.value = prev.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.valid <= 1'b0;
        end else begin
            cur_reg.valid <= cur_next.valid;
        end
        cur_reg.value <= cur_next.value;
    end

    assign cur = cur_reg;

endmodule

[src/swm_max_tree.sv]
// Two-stage registered max tree over the cell row; the second stage is the output word register.
// Depends on swm_pkg.
module swm_max_tree (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_emit,
    input  swm_pkg::cell_t   cells [swm_pkg::WINDOW_MAX],
    output logic             out_valid,
    output swm_pkg::sample_t out_max
);
    import swm_pkg::*;

    sample_t l1_reg  [TREE_GROUPS];
    sample_t l1_next [TREE_GROUPS];
    logic    l1_valid_reg;
    sample_t fin_max;
    sample_t out_max_reg;
    logic    out_valid_reg;

    // Reduce each group of cells, empty cells count as the most negative value
    always_comb begin
        for (int g = 0; g < TREE_GROUPS; g++) begin
            l1_next[g] = SAMPLE_MIN;
            for (int e = 0; e < TREE_FAN; e++) begin
                if (g * TREE_FAN + e < WINDOW_MAX) begin
                    if (cells[g * TREE_FAN + e].valid) begin
                        l1_next[g] = max2(l1_next[g], cells[g * TREE_FAN + e].value);
                    end
                end
            end
        end
    end

    // Reduce the group maxima
    always_comb begin
        fin_max = l1_reg[0];
        for (int g = 1; g < TREE_GROUPS; g++) begin
            fin_max = max2(fin_max, l1_reg[g]);
        end
    end

    // Advance both stages together, hold on a stalled output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            l1_valid_reg  <= in_emit;
            out_valid_reg <= l1_valid_reg;
        end
        if (advance) begin
            l1_reg      <= l1_next;
            out_max_reg <= fin_max;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_max   = out_max_reg;

endmodule

[src/sliding_window_maximum_unit.sv]
// Sliding window maximum unit: top level with the config register, sample count and cell row.
// Depends on swm_pkg, swm_cell and swm_max_tree.
// The unit takes one sample per clock unless the result is stalled. Once window_size samples
// have arrived since reset or the last start_new, it returns the maximum of the last
// window_size samples through three register stages: cell row update, group max stage, final
// max stage. The result word is valid on m_window_max once the final max stage holds it. The
// store is a row of WINDOW_MAX cells that shifts by one on every sample: cell j holds the
// sample j steps old if it is still a candidate, so an entry leaves the window simply by
// running past cell window_size - 1. A stalled result stops the whole pipe; s_ready then
// drops. window_size 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX; write it
// only while the unit is idle.
module sliding_window_maximum_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  swm_pkg::sample_t               s_sample,
    input  logic                           s_start_new,
    output logic                           m_valid,
    input  logic                           m_ready,
    output swm_pkg::sample_t               m_window_max
);
    import swm_pkg::*;

    logic [CFG_BITS-1:0]   wsize_reg;
    logic [WIN_BITS-1:0]   win_k;
    logic [WIN_BITS-1:0]   seen_reg;
    logic [WIN_BITS-1:0]   seen_next;
    logic [WIN_BITS-1:0]   seen_base;
    logic                  emit_reg;
    logic                  emit_next;
    logic                  advance;
    logic                  accept;
    cell_t                 cell_q [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_vec;

    assign cfg_ready = 1'b1;
    assign advance   = ~m_valid | m_ready;
    assign s_ready   = advance;
    assign accept    = s_valid & s_ready;

    // Hold the window size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg <= WSIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            wsize_reg <= cfg_data;
        end
    end

    // Clamp the window size to 1..WINDOW_MAX
    always_comb begin
        if (wsize_reg == '0) begin
            win_k = WIN_BITS'(1);
        end else if (int'(wsize_reg) > WINDOW_MAX) begin
            win_k = WIN_BITS'(WINDOW_MAX);
        end else begin
            win_k = WIN_BITS'(wsize_reg);
        end
    end

    // Count arrivals, saturating at WINDOW_MAX; emit once the window is full
    always_comb begin
        seen_base = s_start_new ? '0 : seen_reg;
        seen_next = (int'(seen_base) < WINDOW_MAX) ? seen_base + WIN_BITS'(1) : seen_base;
        emit_next = accept & (seen_next >= win_k);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            emit_reg <= 1'b0;
        end else begin
            if (accept) begin
                seen_reg <= seen_next;
            end
            if (advance) begin
                emit_reg <= emit_next;
            end
        end
    end

    // Row of store cells, newest at cell 0
    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        cell_t prev_in;
        logic  in_range;

        if (j == 0) begin : g_head
            assign prev_in = '0;
        end else begin : g_link
            assign prev_in = cell_q[j-1];
        end

        assign in_range     = (WIN_BITS'(j) < win_k);
        assign valid_vec[j] = cell_q[j].valid;

        swm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (accept),
            .load_new  (j == 0),
            .start_new (s_start_new),
            .in_range  (in_range),
            .sample    (s_sample),
            .prev      (prev_in),
            .cur       (cell_q[j])
        );
    end

    swm_max_tree u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_emit   (emit_reg),
        .cells     (cell_q),
        .out_valid (m_valid),
        .out_max   (m_window_max)
    );

    // Newest word always lands in the head cell
    a_head_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (cell_q[0].valid && cell_q[0].value == $past(s_sample)))
        else $error("head cell does not hold the accepted word");

    // No more live entries than the window allows
    a_within_window: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ($countones(valid_vec) <= int'($past(win_k))))
        else $error("live entries exceed the window size");

    // A restart leaves only the new word in the store
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_start_new) |=> ($countones(valid_vec) == 1))
        else $error("store not cleared on start_new");

endmodule
